@@ design/rwl_pkg.sv @@
// Shared types and constants of the reader-writer lock unit.
package rwl_pkg;

   localparam int ID_W = 6;
   localparam int REQUESTER_COUNT = 64;
   localparam int RESULT_CAP = 16;
   localparam int WAKE_W = $clog2(RESULT_CAP + 1);

   localparam int DEF_READER_QUEUE_DEPTH = 16;
   localparam int DEF_WRITER_QUEUE_DEPTH = 16;
   localparam int DEF_MAX_READERS = 255;

   typedef enum logic [1:0] {
      ACT_EXCL_LOCK     = 2'd0,
      ACT_EXCL_UNLOCK   = 2'd1,
      ACT_SHARED_LOCK   = 2'd2,
      ACT_SHARED_UNLOCK = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      OUT_GRANTED  = 3'd0,
      OUT_QUEUED   = 3'd1,
      OUT_WAKE     = 3'd2,
      OUT_RELEASED = 3'd3,
      OUT_NOT_HELD = 3'd4,
      OUT_FULL     = 3'd5,
      OUT_LIMIT    = 3'd6
   } outcome_type;

endpackage

@@ design/rwl_if.sv @@
// Valid/ready channel interfaces for lock requests and lock results.
interface rwl_req_if;
   logic                  valid;
   logic                  ready;
   rwl_pkg::action_type   action;
   logic [rwl_pkg::ID_W-1:0] requester;

   modport source (output valid, output action, output requester, input ready);
   modport sink   (input valid, input action, input requester, output ready);
endinterface

interface rwl_rsp_if;
   logic                  valid;
   logic                  ready;
   rwl_pkg::outcome_type  outcome;
   logic [rwl_pkg::ID_W-1:0] target;
   logic                  last;

   modport source (output valid, output outcome, output target, output last, input ready);
   modport sink   (input valid, input outcome, input target, input last, output ready);
endinterface

@@ design/rwl_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module rwl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/rwl_queue.sv @@
// FIFO wait queue of requester ids: head, tail and count around a RAM.
module rwl_queue #(
   parameter int DEPTH = rwl_pkg::DEF_READER_QUEUE_DEPTH,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  logic [rwl_pkg::ID_W-1:0] push_id,
   input  logic                     pop,
   output logic [rwl_pkg::ID_W-1:0] pop_id,
   output logic [CNT_W-1:0]         count
);

   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

   logic [ADDR_W-1:0] head_ff, head_in;
   logic [ADDR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push) begin
         tail_in  = (tail_ff == LAST_ADDR) ? '0 : tail_ff + 1'b1;
         count_in = count_in + 1'b1;
      end
      if (pop) begin
         head_in  = (head_ff == LAST_ADDR) ? '0 : head_ff + 1'b1;
         count_in = count_in - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   rwl_ram #(
      .WIDTH (rwl_pkg::ID_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (tail_ff),
      .wr_data (push_id),
      .rd_en   (pop),
      .rd_addr (head_ff),
      .rd_data (pop_id)
   );

   assign count = count_ff;

endmodule

@@ design/reader_writer_lock_unit.sv @@
// Reader-writer lock unit: top level with request decoding and result sequencing.
//
// Requests arrive on req_if (action, requester) and results leave on rsp_if
// (outcome, target, last). Every request gives one or more result words; the
// word that closes a request carries last high.
// Lock requests and releases that wake nobody give one result word, loaded
// into the output register at the accepting edge, and a new request is taken
// every cycle while the receiver keeps up.
// A release that wakes waiters reads the ids out of the wait queue RAM, one
// at a time through its single read port: the first id is read at the
// accepting edge and loaded into the output register from the wake state,
// the rest follow one per cycle while the receiver keeps up, up to sixteen
// readers per release. No request is taken until the last wake word is loaded.
// When the receiver stalls, the output register holds its word and the unit
// stops taking requests or reading the queue until the word is taken.
// Reset (synchronous, active high) frees the lock and empties both queues;
// queue contents are not cleared and need no clearing pass.
module reader_writer_lock_unit #(
   parameter int READER_QUEUE_DEPTH = rwl_pkg::DEF_READER_QUEUE_DEPTH,
   parameter int WRITER_QUEUE_DEPTH = rwl_pkg::DEF_WRITER_QUEUE_DEPTH,
   parameter int MAX_READERS = rwl_pkg::DEF_MAX_READERS
) (
   input  logic      clock,
   input  logic      reset,
   rwl_req_if.sink   req_if,
   rwl_rsp_if.source rsp_if
);

   localparam int RCNT_W = $clog2(READER_QUEUE_DEPTH + 1);
   localparam int WCNT_W = $clog2(WRITER_QUEUE_DEPTH + 1);
   localparam int HOLD_W = $clog2(MAX_READERS + 2);
   localparam logic [HOLD_W-1:0] HOLD_EXCL = HOLD_W'(MAX_READERS + 1);
   localparam logic [HOLD_W-1:0] HOLD_MAX = HOLD_W'(MAX_READERS);
   localparam logic [HOLD_W-1:0] HOLD_ONE = HOLD_W'(1);
   localparam logic [rwl_pkg::WAKE_W-1:0] WAKE_ONE = rwl_pkg::WAKE_W'(1);

   typedef enum logic {
      ST_IDLE,
      ST_WAKE
   } state_type;

   state_type                       state_ff, state_in;
   logic [HOLD_W-1:0]               hold_ff, hold_in;
   logic [rwl_pkg::WAKE_W-1:0]      wake_left_ff, wake_left_in;
   logic                            wake_writer_ff, wake_writer_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   rwl_pkg::outcome_type            rsp_outcome_ff, rsp_outcome_in;
   logic [rwl_pkg::ID_W-1:0]        rsp_target_ff, rsp_target_in;
   logic                            rsp_last_ff, rsp_last_in;

   logic                            slot_free;
   logic                            req_fire;
   logic                            rq_push, rq_pop, wq_push, wq_pop;
   logic [rwl_pkg::ID_W-1:0]        rq_pop_id, wq_pop_id;
   logic [RCNT_W-1:0]               rq_count;
   logic [WCNT_W-1:0]               wq_count;
   logic                            rq_full, wq_full;

   // Request decode results.
   rwl_pkg::outcome_type            dec_outcome;
   logic [HOLD_W-1:0]               dec_hold;
   logic                            dec_push_r, dec_push_w;
   logic                            dec_wake, dec_wake_writer;
   logic [rwl_pkg::WAKE_W-1:0]      dec_wake_n;

   assign slot_free = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = (state_ff == ST_IDLE) && slot_free;
   assign req_fire = req_if.valid && req_if.ready;
   assign rq_full = (rq_count == RCNT_W'(READER_QUEUE_DEPTH));
   assign wq_full = (wq_count == WCNT_W'(WRITER_QUEUE_DEPTH));

   always_comb begin
      dec_outcome     = rwl_pkg::OUT_NOT_HELD;
      dec_hold        = hold_ff;
      dec_push_r      = 1'b0;
      dec_push_w      = 1'b0;
      dec_wake        = 1'b0;
      dec_wake_writer = 1'b0;
      dec_wake_n      = WAKE_ONE;
      if (32'(req_if.requester) < rwl_pkg::REQUESTER_COUNT) begin
         unique case (req_if.action)
            rwl_pkg::ACT_EXCL_LOCK: begin
               if (hold_ff == '0) begin
                  dec_hold    = HOLD_EXCL;
                  dec_outcome = rwl_pkg::OUT_GRANTED;
               end else if (!wq_full) begin
                  dec_push_w  = 1'b1;
                  dec_outcome = rwl_pkg::OUT_QUEUED;
               end else begin
                  dec_outcome = rwl_pkg::OUT_FULL;
               end
            end
            rwl_pkg::ACT_EXCL_UNLOCK: begin
               if (hold_ff == HOLD_EXCL) begin
                  dec_hold = '0;
                  if (rq_count != '0) begin
                     dec_wake = 1'b1;
                     if (32'(rq_count) > rwl_pkg::RESULT_CAP) begin
                        dec_wake_n = rwl_pkg::WAKE_W'(rwl_pkg::RESULT_CAP);
                     end else begin
                        dec_wake_n = rwl_pkg::WAKE_W'(rq_count);
                     end
                  end else if (wq_count != '0) begin
                     dec_wake        = 1'b1;
                     dec_wake_writer = 1'b1;
                  end else begin
                     dec_outcome = rwl_pkg::OUT_RELEASED;
                  end
               end
            end
            rwl_pkg::ACT_SHARED_LOCK: begin
               if (hold_ff == HOLD_EXCL) begin
                  if (!rq_full) begin
                     dec_push_r  = 1'b1;
                     dec_outcome = rwl_pkg::OUT_QUEUED;
                  end else begin
                     dec_outcome = rwl_pkg::OUT_FULL;
                  end
               end else if (hold_ff >= HOLD_MAX) begin
                  dec_outcome = rwl_pkg::OUT_LIMIT;
               end else begin
                  dec_hold    = hold_ff + 1'b1;
                  dec_outcome = rwl_pkg::OUT_GRANTED;
               end
            end
            rwl_pkg::ACT_SHARED_UNLOCK: begin
               if (hold_ff != '0 && hold_ff != HOLD_EXCL) begin
                  dec_hold = hold_ff - 1'b1;
                  if (hold_ff == HOLD_ONE && wq_count != '0) begin
                     dec_wake        = 1'b1;
                     dec_wake_writer = 1'b1;
                  end else begin
                     dec_outcome = rwl_pkg::OUT_RELEASED;
                  end
               end
            end
            default: begin
               dec_outcome = rwl_pkg::OUT_NOT_HELD;
            end
         endcase
      end
   end

   // Queue accesses: pushes come only from a decoded request, pops from the
   // start of a wake burst and from each wake word that has more to follow.
   always_comb begin
      rq_push = req_fire && dec_push_r;
      wq_push = req_fire && dec_push_w;
      rq_pop  = 1'b0;
      wq_pop  = 1'b0;
      if (req_fire && dec_wake) begin
         rq_pop = !dec_wake_writer;
         wq_pop = dec_wake_writer;
      end else if (state_ff == ST_WAKE && slot_free && wake_left_ff != WAKE_ONE) begin
         rq_pop = !wake_writer_ff;
         wq_pop = wake_writer_ff;
      end
   end

   always_comb begin
      state_in       = state_ff;
      hold_in        = hold_ff;
      wake_left_in   = wake_left_ff;
      wake_writer_in = wake_writer_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_if.ready;
      rsp_outcome_in = rsp_outcome_ff;
      rsp_target_in  = rsp_target_ff;
      rsp_last_in    = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               hold_in = dec_hold;
               if (dec_wake) begin
                  wake_left_in   = dec_wake_n;
                  wake_writer_in = dec_wake_writer;
                  state_in       = ST_WAKE;
               end else begin
                  rsp_valid_in   = 1'b1;
                  rsp_outcome_in = dec_outcome;
                  rsp_target_in  = req_if.requester;
                  rsp_last_in    = 1'b1;
               end
            end
         end
         ST_WAKE: begin
            // The RAM read data holds until the next pop, so a stall just waits.
            if (slot_free) begin
               rsp_valid_in   = 1'b1;
               rsp_outcome_in = rwl_pkg::OUT_WAKE;
               rsp_target_in  = wake_writer_ff ? wq_pop_id : rq_pop_id;
               rsp_last_in    = (wake_left_ff == WAKE_ONE);
               wake_left_in   = wake_left_ff - 1'b1;
               if (wake_left_ff == WAKE_ONE) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         hold_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hold_ff      <= hold_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      wake_left_ff   <= wake_left_in;
      wake_writer_ff <= wake_writer_in;
      rsp_outcome_ff <= rsp_outcome_in;
      rsp_target_ff  <= rsp_target_in;
      rsp_last_ff    <= rsp_last_in;
   end

   rwl_queue #(
      .DEPTH (READER_QUEUE_DEPTH)
   ) u_reader_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (rq_push),
      .push_id (req_if.requester),
      .pop     (rq_pop),
      .pop_id  (rq_pop_id),
      .count   (rq_count)
   );

   rwl_queue #(
      .DEPTH (WRITER_QUEUE_DEPTH)
   ) u_writer_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (wq_push),
      .push_id (req_if.requester),
      .pop     (wq_pop),
      .pop_id  (wq_pop_id),
      .count   (wq_count)
   );

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.outcome = rsp_outcome_ff;
   assign rsp_if.target  = rsp_target_ff;
   assign rsp_if.last    = rsp_last_ff;

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for the reader-writer lock unit.
module tb;

   localparam int READER_DEPTH = rwl_pkg::DEF_READER_QUEUE_DEPTH;
   localparam int WRITER_DEPTH = rwl_pkg::DEF_WRITER_QUEUE_DEPTH;
   localparam int MAX_READERS = rwl_pkg::DEF_MAX_READERS;
   localparam int unsigned HOLD_EXCL = MAX_READERS + 1;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int DRAIN_CYCLES = 40;
   localparam int RANDOM_ITEMS = 56;
   localparam int PRESSURE_ITEMS = 40;
   localparam int HOLD_OFF_CYCLES = 250;

   typedef struct {
      rwl_pkg::outcome_type     outcome;
      logic [rwl_pkg::ID_W-1:0] target;
      logic                     last;
   } lock_result_type;

   logic clock = 1'b0;
   logic reset;

   rwl_req_if req_ch ();
   rwl_rsp_if rsp_ch ();

   reader_writer_lock_unit u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // Predicted lock state.
   int unsigned              lock_holders = 0;
   logic [rwl_pkg::ID_W-1:0] waiting_readers[$];
   logic [rwl_pkg::ID_W-1:0] waiting_writers[$];
   lock_result_type          expected_results[$];

   int mismatch_count = 0;
   int cycle_count = 0;
   bit steady = 1'b0;
   int hold_off_request = 0;
   int hold_off_left = 0;
   int sink_gap_left = 0;

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** reader_writer_lock_unit: FAILED **");
         $finish;
      end
   end

   function automatic int gap_length();
      if ($urandom_range(0, 9) == 0)
         return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   function automatic logic [rwl_pkg::ID_W-1:0] pick_id();
      if ($urandom_range(0, 7) == 0)
         return ($urandom_range(0, 1) != 0) ?
                rwl_pkg::ID_W'(rwl_pkg::REQUESTER_COUNT - 1) : '0;
      return rwl_pkg::ID_W'($urandom_range(0, rwl_pkg::REQUESTER_COUNT - 1));
   endfunction

   // Removes and returns the oldest id of a wait queue.
   function automatic logic [rwl_pkg::ID_W-1:0] take_oldest_id(
         ref logic [rwl_pkg::ID_W-1:0] ids[$]);
      logic [rwl_pkg::ID_W-1:0] oldest;
      oldest = ids[0];
      ids.delete(0);
      return oldest;
   endfunction

   function automatic lock_result_type make_result(rwl_pkg::outcome_type o,
                                                   logic [rwl_pkg::ID_W-1:0] t);
      lock_result_type r;
      r.outcome = o;
      r.target = t;
      r.last = 1'b0;
      return r;
   endfunction

   task automatic predict_lock_results(input rwl_pkg::action_type act,
                                       input logic [rwl_pkg::ID_W-1:0] id);
      lock_result_type burst[$];
      lock_result_type r;
      if (id >= rwl_pkg::REQUESTER_COUNT) begin
         burst.push_back(make_result(rwl_pkg::OUT_NOT_HELD, id));
      end else begin
         case (act)
            rwl_pkg::ACT_EXCL_LOCK: begin
               if (lock_holders == 0) begin
                  lock_holders = HOLD_EXCL;
                  burst.push_back(make_result(rwl_pkg::OUT_GRANTED, id));
               end else if (waiting_writers.size() < WRITER_DEPTH) begin
                  waiting_writers.push_back(id);
                  burst.push_back(make_result(rwl_pkg::OUT_QUEUED, id));
               end else begin
                  burst.push_back(make_result(rwl_pkg::OUT_FULL, id));
               end
            end
            rwl_pkg::ACT_EXCL_UNLOCK: begin
               if (lock_holders != HOLD_EXCL) begin
                  burst.push_back(make_result(rwl_pkg::OUT_NOT_HELD, id));
               end else begin
                  lock_holders = 0;
                  // All waiting readers go first; a writer is woken only if none wait.
                  while (waiting_readers.size() > 0 && burst.size() < rwl_pkg::RESULT_CAP)
                     burst.push_back(make_result(rwl_pkg::OUT_WAKE,
                                                 take_oldest_id(waiting_readers)));
                  if (burst.size() == 0 && waiting_writers.size() > 0)
                     burst.push_back(make_result(rwl_pkg::OUT_WAKE,
                                                 take_oldest_id(waiting_writers)));
                  if (burst.size() == 0)
                     burst.push_back(make_result(rwl_pkg::OUT_RELEASED, id));
               end
            end
            rwl_pkg::ACT_SHARED_LOCK: begin
               if (lock_holders == HOLD_EXCL) begin
                  if (waiting_readers.size() < READER_DEPTH) begin
                     waiting_readers.push_back(id);
                     burst.push_back(make_result(rwl_pkg::OUT_QUEUED, id));
                  end else begin
                     burst.push_back(make_result(rwl_pkg::OUT_FULL, id));
                  end
               end else if (lock_holders >= MAX_READERS) begin
                  burst.push_back(make_result(rwl_pkg::OUT_LIMIT, id));
               end else begin
                  lock_holders++;
                  burst.push_back(make_result(rwl_pkg::OUT_GRANTED, id));
               end
            end
            default: begin
               if (lock_holders == 0 || lock_holders == HOLD_EXCL) begin
                  burst.push_back(make_result(rwl_pkg::OUT_NOT_HELD, id));
               end else begin
                  lock_holders--;
                  if (lock_holders == 0 && waiting_writers.size() > 0)
                     burst.push_back(make_result(rwl_pkg::OUT_WAKE,
                                                 take_oldest_id(waiting_writers)));
                  else
                     burst.push_back(make_result(rwl_pkg::OUT_RELEASED, id));
               end
            end
         endcase
      end
      for (int i = 0; i < burst.size(); i++) begin
         r = burst[i];
         r.last = (i == burst.size() - 1);
         expected_results.push_back(r);
      end
   endtask

   task automatic note_failure(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("ERROR at cycle %0d: %s", cycle_count, msg);
   endtask

   task automatic check_lock_result(input rwl_pkg::outcome_type o,
                                    input logic [rwl_pkg::ID_W-1:0] t,
                                    input logic l);
      lock_result_type want;
      if (expected_results.size() == 0) begin
         note_failure($sformatf("unexpected word: outcome %0d target %0d last %0d",
                                o, t, l));
         return;
      end
      want = expected_results[0];
      expected_results.delete(0);
      if (want.outcome !== o || want.target !== t || want.last !== l)
         note_failure($sformatf({"expected outcome %0d target %0d last %0d, ",
                                 "got outcome %0d target %0d last %0d"},
                                want.outcome, want.target, want.last, o, t, l));
   endtask

   // Result side: checks accepted words and drives ready with random stalls.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         check_lock_result(rsp_ch.outcome, rsp_ch.target, rsp_ch.last);
      if (hold_off_request > 0) begin
         hold_off_left = hold_off_request;
         hold_off_request = 0;
      end
      if (hold_off_left > 0) begin
         hold_off_left--;
         rsp_ch.ready <= 1'b0;
      end else if (sink_gap_left > 0) begin
         sink_gap_left--;
         rsp_ch.ready <= 1'b0;
      end else if (!steady && $urandom_range(0, 4) == 0) begin
         sink_gap_left = gap_length() - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Valid stays high from one word to the next unless a gap is inserted.
   task automatic send_lock_word(input rwl_pkg::action_type act,
                                 input logic [rwl_pkg::ID_W-1:0] id);
      if (!steady && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap_length()) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.action <= act;
      req_ch.requester <= id;
      do @(posedge clock); while (!req_ch.ready);
      predict_lock_results(act, id);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (expected_results.size() != 0);
   endtask

   // Mostly legal lock traffic for the current state, with some noise mixed in.
   function automatic rwl_pkg::action_type choose_action();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 10)
         return rwl_pkg::action_type'($urandom_range(0, 3));
      if (lock_holders == 0)
         return (roll < 55) ? rwl_pkg::ACT_EXCL_LOCK : rwl_pkg::ACT_SHARED_LOCK;
      if (lock_holders == HOLD_EXCL) begin
         if (roll < 50) return rwl_pkg::ACT_EXCL_UNLOCK;
         if (roll < 75) return rwl_pkg::ACT_SHARED_LOCK;
         if (roll < 95) return rwl_pkg::ACT_EXCL_LOCK;
         return rwl_pkg::ACT_SHARED_UNLOCK;
      end
      if (roll < 45) return rwl_pkg::ACT_SHARED_LOCK;
      if (roll < 80) return rwl_pkg::ACT_SHARED_UNLOCK;
      if (roll < 96) return rwl_pkg::ACT_EXCL_LOCK;
      return rwl_pkg::ACT_EXCL_UNLOCK;
   endfunction

   task automatic test_directed_cases();
      send_lock_word(rwl_pkg::ACT_EXCL_UNLOCK, 6'd5);     // release while free
      send_lock_word(rwl_pkg::ACT_SHARED_UNLOCK, 6'd0);   // release while free
      send_lock_word(rwl_pkg::ACT_EXCL_LOCK, 6'd0);
      send_lock_word(rwl_pkg::ACT_EXCL_LOCK, 6'd63);
      // Shared release of an exclusive hold.
      send_lock_word(rwl_pkg::ACT_SHARED_UNLOCK, 6'd7);
      send_lock_word(rwl_pkg::ACT_SHARED_LOCK, 6'd42);
      send_lock_word(rwl_pkg::ACT_SHARED_LOCK, 6'd21);
      // Wakes both readers, the writer stays queued.
      send_lock_word(rwl_pkg::ACT_EXCL_UNLOCK, 6'd0);
      send_lock_word(rwl_pkg::ACT_SHARED_LOCK, 6'd42);
      send_lock_word(rwl_pkg::ACT_SHARED_LOCK, 6'd21);
      send_lock_word(rwl_pkg::ACT_EXCL_LOCK, 6'd1);
      // Exclusive release of a shared hold.
      send_lock_word(rwl_pkg::ACT_EXCL_UNLOCK, 6'd3);
      send_lock_word(rwl_pkg::ACT_SHARED_UNLOCK, 6'd42);
      // The last reader out wakes a writer.
      send_lock_word(rwl_pkg::ACT_SHARED_UNLOCK, 6'd21);
      send_lock_word(rwl_pkg::ACT_EXCL_LOCK, 6'd63);
      // No reader waits, so a writer wakes.
      send_lock_word(rwl_pkg::ACT_EXCL_UNLOCK, 6'd63);
      send_lock_word(rwl_pkg::ACT_EXCL_LOCK, 6'd1);
      send_lock_word(rwl_pkg::ACT_EXCL_UNLOCK, 6'd1);
      send_lock_word(rwl_pkg::ACT_SHARED_LOCK, 6'd63);
      send_lock_word(rwl_pkg::ACT_SHARED_UNLOCK, 6'd63);
   endtask

   task automatic test_queue_full();
      send_lock_word(rwl_pkg::ACT_EXCL_LOCK, pick_id());
      repeat (WRITER_DEPTH + 1) send_lock_word(rwl_pkg::ACT_EXCL_LOCK, pick_id());
      repeat (READER_DEPTH + 1) send_lock_word(rwl_pkg::ACT_SHARED_LOCK, pick_id());
      // Releasing now wakes the largest possible burst of readers.
      send_lock_word(rwl_pkg::ACT_EXCL_UNLOCK, pick_id());
   endtask

   // Fills the lock with readers up to the limit; it runs last, so the
   // readers are left holding.
   task automatic test_reader_limit();
      if (lock_holders == HOLD_EXCL)
         send_lock_word(rwl_pkg::ACT_EXCL_UNLOCK, pick_id());
      repeat (MAX_READERS + 2) send_lock_word(rwl_pkg::ACT_SHARED_LOCK, pick_id());
      send_lock_word(rwl_pkg::ACT_EXCL_LOCK, pick_id());
   endtask

   task automatic test_random_traffic();
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 50 == 0)
            steady = ($urandom_range(0, 3) == 0);
         send_lock_word(choose_action(), pick_id());
      end
      steady = 1'b0;
   endtask

   // The receiver stops for a long stretch while requests keep coming back to back.
   task automatic test_backpressure();
      steady = 1'b1;
      hold_off_request = HOLD_OFF_CYCLES;
      repeat (PRESSURE_ITEMS) send_lock_word(choose_action(), pick_id());
      steady = 1'b0;
      wait_drained();
   endtask

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.action = rwl_pkg::ACT_EXCL_LOCK;
      req_ch.requester = '0;
      rsp_ch.ready = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      wait_drained();
      test_queue_full();
      wait_drained();
      test_random_traffic();
      test_backpressure();
      test_reader_limit();
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0)
         $display("** reader_writer_lock_unit: PASSED **");
      else
         $display("** reader_writer_lock_unit: FAILED **");
      $finish;
   end

endmodule
